// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/nfd_pkg.sv
`timescale 1ns / 1ps
package nfd_pkg;
    localparam int TableEntries = 64;
    localparam int SlotW = $clog2(TableEntries);

    typedef enum logic [1:0] {CMD_BYTE = 2'd0, CMD_REG = 2'd1, CMD_DEL = 2'd2,
                              CMD_NOP = 2'd3} cmd_t;
    typedef enum logic [2:0] {K_PAYLOAD = 3'd0, K_EMPTY = 3'd1, K_DONE = 3'd2,
                              K_MISMATCH = 3'd3, K_MALFORMED = 3'd4, K_OK = 3'd5,
                              K_FULL = 3'd6, K_NOTFOUND = 3'd7} kind_t;
    typedef enum logic [3:0] {PH_COUNT = 4'd0, PH_LEN = 4'd1, PH_NSTAMPS = 4'd2,
                              PH_TIME = 4'd3, PH_NSAMPLES = 4'd4, PH_HANDLE = 4'd5,
                              PH_SIZE = 4'd6, PH_PAYLOAD = 4'd7, PH_SKIP = 4'd8}
                              phase_t;

    // Handle lookup result handed from the table to the parser.
    typedef struct packed {
        logic             hit;
        logic [SlotW-1:0] slot;
        logic             free_ok;
        logic [SlotW-1:0] free_slot;
    } look_t;
endpackage

// File: sv/notification_frame_dispatcher.sv
`timescale 1ns / 1ps
// notification_frame_dispatcher
// Input channel (in_valid/in_stall) carries one request: a stream byte of a
// little-endian notification frame, a register/remove of a handle, or a no-op.
// Output channel (out_valid/out_stall) carries at most one result per request:
// payload bytes with slot, time and end marks, empty samples, frame done, size
// mismatch, malformed, and table answers.
// A request is looked up in the cycle it is accepted; the size comparison of
// a sample's last size byte happens in the next cycle after the size RAM
// read, and the result sits in the output register the cycle after.
// Throughput: one request per cycle while no stall holds the input. Besides
// the receiver stall below, only the last size byte of a sample stalls the
// input, while the size RAM read (single stage) completes.
// Reset: table empty, parser waits for a frame byte count.
// Receiver stall: the output register holds; the input is stalled for as long
// as a held result waits under the receiver's stall.
module notification_frame_dispatcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [31:0] handle,
    input  logic [31:0] sample_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [5:0]  slot,
    output logic [31:0] handle_res,
    output logic [63:0] timestamp,
    output logic [7:0]  data_byte_res,
    output logic        sample_last,
    output logic        frame_last
);
    import nfd_pkg::*;

    // parser state
    phase_t      phase_reg;
    logic [2:0]  fcnt_reg;
    logic [63:0] shift_reg;
    logic [31:0] left_reg, stamps_reg, samples_reg, pay_reg, shandle_reg;
    logic [63:0] time_reg;
    logic [SlotW-1:0] sslot_reg;
    logic        known_reg;
    // pending size check (after size RAM read)
    logic        pend_reg;
    logic        phit_reg;
    logic [31:0] psize_reg;

    logic        ov_reg;
    logic [2:0]  k_reg;
    logic [5:0]  s_reg;
    logic [31:0] h_reg;
    logic [63:0] t_reg;
    logic [7:0]  d_reg;
    logic        sl_reg, fl_reg;

    look_t       look;
    logic [31:0] size_rdata;
    logic [31:0] look_h;
    logic        take;

    assign in_stall = pend_reg || (ov_reg && out_stall);
    assign take     = in_valid && !in_stall;
    assign look_h   = (cmd == CMD_BYTE) ? shandle_reg : handle;

    // next-state variables
    phase_t      phase_next;
    logic [2:0]  fcnt_next;
    logic [63:0] shift_next, time_next;
    logic [31:0] left_next, stamps_next, samples_next, pay_next, shandle_next;
    logic [SlotW-1:0] sslot_next;
    logic        known_next, pend_next, phit_next;
    logic [31:0] psize_next;
    logic        ev, evend;
    logic [2:0]  ek;
    logic [5:0]  es;
    logic [31:0] eh;
    logic [63:0] et;
    logic [7:0]  ed;
    logic        esl;
    logic        wr_en, del_en;
    logic [SlotW-1:0] wr_slot;
    logic [3:0]  width;
    logic [3:0]  need;
    logic [63:0] v;

    always_comb
    begin
        phase_next = phase_reg; fcnt_next = fcnt_reg; shift_next = shift_reg;
        time_next = time_reg; left_next = left_reg; stamps_next = stamps_reg;
        samples_next = samples_reg; pay_next = pay_reg; shandle_next = shandle_reg;
        sslot_next = sslot_reg; known_next = known_reg; pend_next = 1'b0;
        phit_next = phit_reg; psize_next = psize_reg;
        ev = 1'b0; evend = 1'b0; ek = K_DONE; es = '0; eh = '0; et = '0; ed = '0;
        esl = 1'b0; wr_en = 1'b0; del_en = 1'b0; wr_slot = look.free_slot;
        width = 4'd4; need = 4'd0; v = '0;

        if (pend_reg)
        begin
            // Finish the size check of a sample; no request taken this cycle.
            if (phit_reg && psize_reg != size_rdata)
            begin
                ev = 1'b1; ek = K_MISMATCH; es = 6'(sslot_reg); eh = shandle_reg;
                et = time_reg;
                if (left_reg == 0) evend = 1'b1; else phase_next = PH_SKIP;
            end
            else if (psize_reg > left_reg)
            begin
                ev = 1'b1; ek = K_MALFORMED;
                if (left_reg == 0) evend = 1'b1; else phase_next = PH_SKIP;
            end
            else if (psize_reg == 0)
            begin
                if (phit_reg)
                begin
                    ev = 1'b1; ek = K_EMPTY; es = 6'(sslot_reg); eh = shandle_reg;
                    et = time_reg;
                end
                if (samples_reg != 0)
                begin
                    samples_next = samples_reg - 1;
                    if (left_reg == 0)
                    begin
                        if (!ev) begin ev = 1'b1; ek = K_MALFORMED; end
                        evend = 1'b1;
                    end
                    else phase_next = PH_HANDLE;
                end
                else if (stamps_reg != 0)
                begin
                    stamps_next = stamps_reg - 1;
                    if (left_reg == 0)
                    begin
                        if (!ev) begin ev = 1'b1; ek = K_MALFORMED; end
                        evend = 1'b1;
                    end
                    else phase_next = PH_TIME;
                end
                else if (left_reg == 0) evend = 1'b1;
                else phase_next = PH_SKIP;
            end
            else
            begin
                pay_next = psize_reg; known_next = phit_reg; phase_next = PH_PAYLOAD;
            end
        end
        else if (take)
        begin
            unique case (cmd_t'(cmd))
                CMD_REG:
                begin
                    ev = 1'b1; eh = handle;
                    if (look.hit)
                    begin
                        ek = K_OK; es = 6'(look.slot);
                    end
                    else if (look.free_ok)
                    begin
                        ek = K_OK; es = 6'(look.free_slot); wr_en = 1'b1;
                    end
                    else ek = K_FULL;
                end
                CMD_DEL:
                begin
                    ev = 1'b1; eh = handle;
                    if (look.hit)
                    begin
                        ek = K_OK; es = 6'(look.slot); del_en = 1'b1;
                    end
                    else ek = K_NOTFOUND;
                end
                CMD_NOP: ;
                default:
                begin
                    if (phase_reg == PH_PAYLOAD)
                    begin
                        if (left_reg != 0) left_next = left_reg - 1;
                        if (pay_reg != 0) pay_next = pay_reg - 1;
                        if (known_reg)
                        begin
                            ev = 1'b1; ek = K_PAYLOAD; es = 6'(sslot_reg);
                            eh = shandle_reg; et = time_reg; ed = data_byte;
                            esl = (pay_next == 0);
                        end
                        if (pay_next == 0)
                        begin
                            if (samples_reg != 0)
                            begin
                                samples_next = samples_reg - 1;
                                if (left_next == 0)
                                begin
                                    if (!ev) begin ev = 1'b1; ek = K_MALFORMED; end
                                    evend = 1'b1;
                                end
                                else phase_next = PH_HANDLE;
                            end
                            else if (stamps_reg != 0)
                            begin
                                stamps_next = stamps_reg - 1;
                                if (left_next == 0)
                                begin
                                    if (!ev) begin ev = 1'b1; ek = K_MALFORMED; end
                                    evend = 1'b1;
                                end
                                else phase_next = PH_TIME;
                            end
                            else if (left_next == 0) evend = 1'b1;
                            else phase_next = PH_SKIP;
                        end
                    end
                    else if (phase_reg == PH_SKIP)
                    begin
                        if (left_reg != 0) left_next = left_reg - 1;
                        if (left_next == 0) evend = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg == PH_LEN || phase_reg == PH_HANDLE) need = 4'd8;
                        else if (phase_reg == PH_TIME) need = 4'd12;
                        if (phase_reg == PH_TIME) width = 4'd8;
                        if (fcnt_reg == 0 && need != 0 && left_reg < 32'(need))
                        begin
                            if (left_reg != 0) left_next = left_reg - 1;
                            ev = 1'b1; ek = K_MALFORMED;
                            if (left_next == 0) evend = 1'b1;
                            else phase_next = PH_SKIP;
                        end
                        else
                        begin
                            if (phase_reg != PH_COUNT && left_reg != 0)
                                left_next = left_reg - 1;
                            v = shift_reg | (64'(data_byte) << {fcnt_reg, 3'b000});
                            if ({1'b0, fcnt_reg} + 4'd1 < width)
                            begin
                                shift_next = v; fcnt_next = fcnt_reg + 3'd1;
                            end
                            else
                            begin
                                shift_next = '0; fcnt_next = '0;
                                unique case (phase_reg)
                                    PH_LEN:      phase_next = PH_NSTAMPS;
                                    PH_TIME:
                                    begin
                                        time_next = v; phase_next = PH_NSAMPLES;
                                    end
                                    PH_HANDLE:
                                    begin
                                        shandle_next = v[31:0]; phase_next = PH_SIZE;
                                    end
                                    PH_SIZE:
                                    begin
                                        // table read in this cycle, compare next
                                        pend_next = 1'b1; phit_next = look.hit;
                                        sslot_next = look.hit ? look.slot : '0;
                                        psize_next = v[31:0];
                                    end
                                    PH_NSTAMPS, PH_NSAMPLES:
                                    begin
                                        if (phase_reg == PH_NSAMPLES && v[31:0] != 0)
                                        begin
                                            samples_next = v[31:0] - 1;
                                            if (left_next == 0)
                                            begin
                                                ev = 1'b1; ek = K_MALFORMED;
                                                evend = 1'b1;
                                            end
                                            else phase_next = PH_HANDLE;
                                        end
                                        else
                                        begin
                                            if (phase_reg == PH_NSAMPLES)
                                                samples_next = '0;
                                            if (phase_reg == PH_NSTAMPS)
                                                stamps_next = v[31:0];
                                            else
                                                stamps_next = stamps_reg;
                                            if (stamps_next != 0)
                                            begin
                                                stamps_next = stamps_next - 1;
                                                if (left_next == 0)
                                                begin
                                                    ev = 1'b1; ek = K_MALFORMED;
                                                    evend = 1'b1;
                                                end
                                                else phase_next = PH_TIME;
                                            end
                                            else if (left_next == 0) evend = 1'b1;
                                            else phase_next = PH_SKIP;
                                        end
                                    end
                                    default:
                                    begin
                                        left_next = v[31:0];
                                        if (v[31:0] == 0)
                                        begin
                                            ev = 1'b1; ek = K_MALFORMED;
                                            evend = 1'b1;
                                        end
                                        else phase_next = PH_LEN;
                                    end
                                endcase
                            end
                        end
                    end
                end
            endcase
        end

        if (evend)
        begin
            if (!ev) begin ev = 1'b1; ek = K_DONE; end
            phase_next = PH_COUNT; fcnt_next = '0; shift_next = '0; left_next = '0;
            stamps_next = '0; samples_next = '0; pay_next = '0; known_next = 1'b0;
        end
    end

    nfd_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .look_handle(look_h),
        .look       (look),
        .wr_en      (wr_en),
        .wr_slot    (wr_slot),
        .wr_handle  (handle),
        .wr_size    (sample_size),
        .del_en     (del_en),
        .del_slot   (look.slot),
        .size_raddr (look.slot),
        .size_rdata (size_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT; fcnt_reg <= '0; shift_reg <= '0; time_reg <= '0;
            left_reg <= '0; stamps_reg <= '0; samples_reg <= '0; pay_reg <= '0;
            shandle_reg <= '0; sslot_reg <= '0; known_reg <= 1'b0;
            pend_reg <= 1'b0; phit_reg <= 1'b0; psize_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; fcnt_reg <= fcnt_next; shift_reg <= shift_next;
            time_reg <= time_next; left_reg <= left_next; stamps_reg <= stamps_next;
            samples_reg <= samples_next; pay_reg <= pay_next;
            shandle_reg <= shandle_next; sslot_reg <= sslot_next;
            known_reg <= known_next; pend_reg <= pend_next; phit_reg <= phit_next;
            psize_reg <= psize_next;
            if (ev) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev)
        begin
            k_reg <= ek; s_reg <= es; h_reg <= eh; t_reg <= et; d_reg <= ed;
            sl_reg <= esl; fl_reg <= evend;
        end
    end

    assign out_valid = ov_reg;
    assign kind = k_reg; assign slot = s_reg; assign handle_res = h_reg;
    assign timestamp = t_reg; assign data_byte_res = d_reg;
    assign sample_last = sl_reg; assign frame_last = fl_reg;

`include "assert_macros.svh"
    `CHK_IMPL(a_ev_room, clk, rst_n, ev, !(ov_reg && out_stall))
    `CHK_NEXT(a_pend_one, clk, rst_n, pend_reg, !pend_reg)
    `CHK_NEXT(a_hold, clk, rst_n, ov_reg && out_stall, ov_reg && $stable(k_reg))
endmodule

// File: sv/nfd_ram.sv
`timescale 1ns / 1ps
module nfd_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/nfd_table.sv
`timescale 1ns / 1ps
// Handle table: valid bits and handles in flops for the parallel compare,
// sizes in a RAM whose registered read data follows in the cycle after the lookup.
module nfd_table (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [31:0]              look_handle,
    output nfd_pkg::look_t           look,
    input  logic                     wr_en,
    input  logic [nfd_pkg::SlotW-1:0] wr_slot,
    input  logic [31:0]              wr_handle,
    input  logic [31:0]              wr_size,
    input  logic                     del_en,
    input  logic [nfd_pkg::SlotW-1:0] del_slot,
    input  logic [nfd_pkg::SlotW-1:0] size_raddr,
    output logic [31:0]              size_rdata
);
    import nfd_pkg::*;

    logic [TableEntries-1:0] valid_reg;
    logic [31:0]             handle_reg [TableEntries];

    always_comb
    begin
        look = '0;
        for (int i = TableEntries - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && handle_reg[i] == look_handle)
            begin
                look.hit  = 1'b1;
                look.slot = SlotW'(i);
            end
            if (!valid_reg[i])
            begin
                look.free_ok   = 1'b1;
                look.free_slot = SlotW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (del_en)
            begin
                valid_reg[del_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            handle_reg[wr_slot] <= wr_handle;
        end
    end

    nfd_ram #(.Width(32), .Depth(TableEntries)) u_size (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_slot),
        .wdata(wr_size),
        .raddr(size_raddr),
        .rdata(size_rdata)
    );

`include "assert_macros.svh"
    `CHK_NEXT(a_wr_sets, clk, rst_n, wr_en, valid_reg[$past(wr_slot)])
    `CHK_IMPL(a_no_both, clk, rst_n, wr_en && del_en, 1'b0)
    `CHK_IMPL(a_hit_valid, clk, rst_n, look.hit, valid_reg[look.slot])
endmodule
